### hw/rtl/csl_pkg.sv
// Shared types, token codes and character tables for the C subset lexer.
`default_nettype none

package csl_pkg;

  typedef enum logic [2:0] {
    MODE_IDLE,
    MODE_IDENT,
    MODE_NUMBER,
    MODE_STRING,
    MODE_OPER
  } mode_t;

  // Token codes
  localparam logic [5:0] TK_NULL      = 6'd0;
  localparam logic [5:0] TK_ID        = 6'd1;
  localparam logic [5:0] TK_END       = 6'd18;
  localparam logic [5:0] TK_INT_CONST = 6'd43;
  localparam logic [5:0] TK_STRING    = 6'd44;
  localparam logic [5:0] TK_ERROR     = 6'd46;

  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_UNDER = 8'h5f;

  // Keyword text window: all keywords fit in six characters
  localparam int KW_TEXT_LEN = 6;
  localparam int KW_COUNT    = 11;

  typedef logic [0:KW_TEXT_LEN-1][7:0] kw_text_t;

  localparam kw_text_t KW_TEXT [KW_COUNT] = '{
    {"void", 16'h0}, {"int", 24'h0}, {"float", 8'h0}, {"char", 16'h0},
    {"for", 24'h0}, {"while", 8'h0}, {"do", 32'h0}, {"if", 32'h0},
    {"else", 16'h0}, "return", "struct"
  };
  localparam logic [2:0] KW_LEN [KW_COUNT] = '{
    3'd4, 3'd3, 3'd5, 3'd4, 3'd3, 3'd5, 3'd2, 3'd2, 3'd4, 3'd6, 3'd6
  };
  localparam logic [5:0] KW_KIND [KW_COUNT] = '{
    6'd2, 6'd3, 6'd4, 6'd16, 6'd35, 6'd36, 6'd37, 6'd38, 6'd39, 6'd40, 6'd45
  };

  typedef struct packed {
    logic [5:0] kind;
    logic [7:0] len;
    logic       last;
  } res_t;

  // Results raised by one accepted byte: up to two, r0 first
  typedef struct packed {
    logic [1:0] cnt;
    res_t       r0;
    res_t       r1;
  } push_t;

  function automatic logic is_alpha(input logic [7:0] b);
    return (b >= "a" && b <= "z") || (b >= "A" && b <= "Z") || b == CH_UNDER;
  endfunction

  function automatic logic is_digit(input logic [7:0] b);
    return b >= "0" && b <= "9";
  endfunction

  function automatic logic is_space(input logic [7:0] b);
    return b == 8'h20 || b == 8'h0a || b == 8'h09 || b == 8'h0d;
  endfunction

  function automatic logic op_is_first(input logic [7:0] b);
    return b == "=" || b == "+" || b == "-" || b == "|" ||
           b == "&" || b == "!" || b == ">" || b == "<";
  endfunction

  function automatic logic [2:0] op_index(input logic [7:0] b);
    logic [2:0] idx;
    case (b)
      "=":     idx = 3'd0;
      "+":     idx = 3'd1;
      "-":     idx = 3'd2;
      "|":     idx = 3'd3;
      "&":     idx = 3'd4;
      "!":     idx = 3'd5;
      ">":     idx = 3'd6;
      "<":     idx = 3'd7;
      default: idx = 3'd0;
    endcase
    return idx;
  endfunction

  function automatic logic [7:0] op_second(input logic [2:0] idx);
    logic [7:0] c;
    case (idx)
      3'd1:    c = "+";
      3'd2:    c = "-";
      3'd3:    c = "|";
      3'd4:    c = "&";
      default: c = "=";
    endcase
    return c;
  endfunction

  function automatic logic [5:0] op_double(input logic [2:0] idx);
    logic [5:0] k;
    case (idx)
      3'd0:    k = 6'd29;
      3'd1:    k = 6'd14;
      3'd2:    k = 6'd19;
      3'd3:    k = 6'd27;
      3'd4:    k = 6'd26;
      3'd5:    k = 6'd30;
      3'd6:    k = 6'd33;
      default: k = 6'd34;
    endcase
    return k;
  endfunction

  function automatic logic [5:0] op_single(input logic [2:0] idx);
    logic [5:0] k;
    case (idx)
      3'd0:    k = 6'd9;
      3'd1:    k = 6'd13;
      3'd2:    k = 6'd17;
      3'd3:    k = 6'd23;
      3'd4:    k = 6'd22;
      3'd5:    k = 6'd28;
      3'd6:    k = 6'd31;
      default: k = 6'd32;
    endcase
    return k;
  endfunction

  // Zero when the byte is no single-character token
  function automatic logic [5:0] single_kind(input logic [7:0] b);
    logic [5:0] k;
    case (b)
      "*":     k = 6'd15;
      "/":     k = 6'd20;
      "%":     k = 6'd21;
      "(":     k = 6'd7;
      ")":     k = 6'd8;
      "{":     k = 6'd11;
      "}":     k = 6'd12;
      ",":     k = 6'd5;
      ";":     k = 6'd10;
      ":":     k = 6'd6;
      "^":     k = 6'd24;
      "~":     k = 6'd25;
      "[":     k = 6'd41;
      "]":     k = 6'd42;
      default: k = 6'd0;
    endcase
    return k;
  endfunction

  // len of 7 stands for "longer than any keyword"
  function automatic logic [5:0] ident_kind(input kw_text_t text, input logic [2:0] len);
    logic [5:0] kind;
    logic       eq;
    kind = TK_ID;
    for (int k = KW_COUNT - 1; k >= 0; k--) begin
      eq = (len == KW_LEN[k]);
      for (int i = 0; i < KW_TEXT_LEN; i++) begin
        if (i < int'(KW_LEN[k]) && text[i] != KW_TEXT[k][i]) begin
          eq = 1'b0;
        end
      end
      if (eq) begin
        kind = KW_KIND[k];
      end
    end
    return kind;
  endfunction

endpackage

`default_nettype wire

### hw/rtl/c_subset_lexer_core.sv
// Top level of the C subset lexer: byte stream in, token codes out.
//
//   channel | direction | handshake          | payload
//   in_     | input     | in_valid/in_ready  | in_byte, in_end_of_input
//   out_    | output    | out_valid/out_ready| out_token_kind, out_lexeme_length, out_last
//
// One byte per cycle while in_ready is high. A byte is decided in the cycle it is
// transferred; its results are registered into a four-entry result queue and leave it in order.
// in_ready drops while fewer than two queue slots are free; a stalled output
// side holds up input only through that queue.
// Reset (rst_n low, synchronous) empties the queue and idles the scanner.
`default_nettype none

module c_subset_lexer_core #(
  parameter int KEYWORD_CHARS = 6,
  parameter int LENGTH_MAX    = 255
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [7:0] in_byte,
  input  wire logic       in_end_of_input,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic [5:0]      out_token_kind,
  output logic [7:0]      out_lexeme_length,
  output logic            out_last
);

  logic           in_acc;
  csl_pkg::push_t push;
  csl_pkg::res_t  out_res;

  assign in_acc = in_valid && in_ready;

  csl_scan #(
    .KEYWORD_CHARS (KEYWORD_CHARS),
    .LENGTH_MAX    (LENGTH_MAX)
  ) u_scan (
    .clk     (clk),
    .rst_n   (rst_n),
    .acc     (in_acc),
    .in_byte (in_byte),
    .in_eoi  (in_end_of_input),
    .push    (push)
  );

  csl_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .room      (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_res   (out_res)
  );

  assign out_token_kind    = out_res.kind;
  assign out_lexeme_length = out_res.len;
  assign out_last          = out_res.last;

  // End of input always yields a result on the next cycle
  a_eoi_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_end_of_input |=> out_valid)
    else $error("no result after end of input");

  // The second result of a byte is queued together with the first
  a_pair_follows: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && !out_last |=> out_valid)
    else $error("first of two results not followed by second");

  // End token closes its byte and carries no characters
  a_end_token: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_token_kind == csl_pkg::TK_END |-> out_last && out_lexeme_length == 8'd0)
    else $error("malformed end token");

  // Results never come out of an empty queue right after reset
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result present after reset");

endmodule

`default_nettype wire

### hw/rtl/csl_fifo.sv
// Result queue: takes up to two results a cycle, gives one a cycle while out_ready is high.
`default_nettype none

module csl_fifo (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire csl_pkg::push_t push,
  output logic                room,
  output logic                out_valid,
  input  wire logic           out_ready,
  output csl_pkg::res_t       out_res
);

  localparam int DEPTH = 4;
  localparam int PW    = $clog2(DEPTH);

  csl_pkg::res_t  mem_r [DEPTH];
  logic [PW-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [PW:0]    cnt_r, cnt_nxt;
  logic           pop;
  logic [PW-1:0]  wr_ptr_p1;

  assign out_valid = (cnt_r != '0);
  assign out_res   = mem_r[rd_ptr_r];
  assign pop       = out_valid && out_ready;
  // Keep space for the two results one byte may raise
  assign room      = (cnt_r <= (PW+1)'(DEPTH - 2));
  assign wr_ptr_p1 = wr_ptr_r + PW'(1);

  always_comb begin
    wr_ptr_nxt = wr_ptr_r + PW'(push.cnt);
    rd_ptr_nxt = pop ? rd_ptr_r + PW'(1) : rd_ptr_r;
    cnt_nxt    = cnt_r + (PW+1)'(push.cnt) - (PW+1)'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push.cnt != 2'd0) begin
      mem_r[wr_ptr_r] <= push.r0;
    end
    if (push.cnt == 2'd2) begin
      mem_r[wr_ptr_p1] <= push.r1;
    end
  end

endmodule

`default_nettype wire

### hw/rtl/csl_scan.sv
// Scanner state and per-byte token decision.
`default_nettype none

module csl_scan #(
  parameter int KEYWORD_CHARS = 6,
  parameter int LENGTH_MAX    = 255
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       acc,
  input  wire logic [7:0] in_byte,
  input  wire logic       in_eoi,
  output csl_pkg::push_t  push
);

  localparam int TL_W  = $clog2(LENGTH_MAX + 1);
  localparam int IDX_W = $clog2(KEYWORD_CHARS);

  csl_pkg::mode_t    mode_r, mode_nxt;
  logic [2:0]        pend_r, pend_nxt;
  logic [TL_W-1:0]   tlen_r, tlen_nxt;
  logic [7:0]        ident_r [KEYWORD_CHARS];

  logic              id_we;
  logic [IDX_W-1:0]  id_widx;

  logic [TL_W-1:0]   tlen_grow;
  logic [TL_W+7:0]   tlen_ext, grow_ext;
  csl_pkg::kw_text_t kw_buf;
  logic [2:0]        kw_len;
  logic [5:0]        kw_kind;
  logic [5:0]        sgl_kind;
  logic              alpha, digit, cont_ident, cont_number, cont_oper;

  logic              fl_v, em_v;
  csl_pkg::res_t     fl_res, em_res;

  assign tlen_grow = (tlen_r < TL_W'(LENGTH_MAX)) ? tlen_r + TL_W'(1) : tlen_r;
  assign tlen_ext  = {8'd0, tlen_r};
  assign grow_ext  = {8'd0, tlen_grow};

  always_comb begin
    for (int i = 0; i < csl_pkg::KW_TEXT_LEN; i++) begin
      kw_buf[i] = ident_r[i];
    end
  end

  assign kw_len   = (tlen_r <= TL_W'(csl_pkg::KW_TEXT_LEN)) ? tlen_r[2:0] : 3'd7;
  assign kw_kind  = csl_pkg::ident_kind(kw_buf, kw_len);
  assign sgl_kind = csl_pkg::single_kind(in_byte);
  assign alpha    = csl_pkg::is_alpha(in_byte);
  assign digit    = csl_pkg::is_digit(in_byte);

  assign cont_ident  = !in_eoi && mode_r == csl_pkg::MODE_IDENT && (alpha || digit);
  assign cont_number = !in_eoi && mode_r == csl_pkg::MODE_NUMBER && digit;
  assign cont_oper   = !in_eoi && mode_r == csl_pkg::MODE_OPER &&
                       in_byte == csl_pkg::op_second(pend_r);

  // Next state
  always_comb begin
    mode_nxt = mode_r;
    pend_nxt = pend_r;
    tlen_nxt = tlen_r;
    id_we    = 1'b0;
    id_widx  = tlen_r[IDX_W-1:0];
    if (in_eoi) begin
      mode_nxt = csl_pkg::MODE_IDLE;
      pend_nxt = 3'd0;
      tlen_nxt = '0;
    end else if (cont_ident) begin
      id_we    = (tlen_r < TL_W'(KEYWORD_CHARS));
      tlen_nxt = tlen_grow;
    end else if (cont_number) begin
      tlen_nxt = tlen_grow;
    end else if (mode_r == csl_pkg::MODE_STRING) begin
      if (in_byte == csl_pkg::CH_QUOTE) begin
        mode_nxt = csl_pkg::MODE_IDLE;
        tlen_nxt = '0;
      end else begin
        tlen_nxt = tlen_grow;
      end
    end else if (cont_oper) begin
      mode_nxt = csl_pkg::MODE_IDLE;
      pend_nxt = 3'd0;
    end else begin
      // Close any open token, then start on this byte
      mode_nxt = csl_pkg::MODE_IDLE;
      pend_nxt = 3'd0;
      tlen_nxt = '0;
      if (alpha) begin
        mode_nxt = csl_pkg::MODE_IDENT;
        tlen_nxt = TL_W'(1);
        id_we    = 1'b1;
        id_widx  = '0;
      end else if (digit) begin
        mode_nxt = csl_pkg::MODE_NUMBER;
        tlen_nxt = TL_W'(1);
      end else if (in_byte == csl_pkg::CH_QUOTE) begin
        mode_nxt = csl_pkg::MODE_STRING;
        tlen_nxt = TL_W'(1);
      end else if (csl_pkg::op_is_first(in_byte)) begin
        mode_nxt = csl_pkg::MODE_OPER;
        pend_nxt = csl_pkg::op_index(in_byte);
      end
    end
  end

  // Results
  always_comb begin
    fl_v   = 1'b0;
    fl_res = '0;
    em_v   = 1'b0;
    em_res = '0;
    case (mode_r)
      csl_pkg::MODE_IDENT: begin
        fl_v   = 1'b1;
        fl_res = '{kind: kw_kind, len: tlen_ext[7:0], last: 1'b0};
      end
      csl_pkg::MODE_NUMBER: begin
        fl_v   = 1'b1;
        fl_res = '{kind: csl_pkg::TK_INT_CONST, len: tlen_ext[7:0], last: 1'b0};
      end
      csl_pkg::MODE_STRING: begin
        fl_v   = 1'b1;
        fl_res = '{kind: csl_pkg::TK_ERROR, len: tlen_ext[7:0], last: 1'b0};
      end
      csl_pkg::MODE_OPER: begin
        fl_v   = 1'b1;
        fl_res = '{kind: csl_pkg::op_single(pend_r), len: 8'd1, last: 1'b0};
      end
      default: begin
        fl_v = 1'b0;
      end
    endcase

    if (in_eoi) begin
      em_v   = 1'b1;
      em_res = '{kind: csl_pkg::TK_END, len: 8'd0, last: 1'b0};
    end else if (cont_ident || cont_number) begin
      fl_v = 1'b0;
    end else if (mode_r == csl_pkg::MODE_STRING) begin
      fl_v   = 1'b0;
      em_v   = (in_byte == csl_pkg::CH_QUOTE);
      em_res = '{kind: csl_pkg::TK_STRING, len: grow_ext[7:0], last: 1'b0};
    end else if (cont_oper) begin
      fl_v   = 1'b0;
      em_v   = 1'b1;
      em_res = '{kind: csl_pkg::op_double(pend_r), len: 8'd2, last: 1'b0};
    end else if (alpha || digit || in_byte == csl_pkg::CH_QUOTE ||
                 csl_pkg::op_is_first(in_byte) || csl_pkg::is_space(in_byte)) begin
      em_v = 1'b0;
    end else if (sgl_kind != 6'd0) begin
      em_v   = 1'b1;
      em_res = '{kind: sgl_kind, len: 8'd1, last: 1'b0};
    end else if (in_byte == 8'h00) begin
      em_v   = 1'b1;
      em_res = '{kind: csl_pkg::TK_NULL, len: 8'd0, last: 1'b0};
    end else begin
      em_v   = 1'b1;
      em_res = '{kind: csl_pkg::TK_ERROR, len: 8'd1, last: 1'b0};
    end

    push.cnt = 2'd0;
    push.r0  = fl_res;
    push.r1  = em_res;
    if (acc) begin
      if (fl_v && em_v) begin
        push.cnt     = 2'd2;
        push.r1.last = 1'b1;
      end else if (fl_v) begin
        push.cnt     = 2'd1;
        push.r0.last = 1'b1;
      end else if (em_v) begin
        push.cnt     = 2'd1;
        push.r0      = em_res;
        push.r0.last = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= csl_pkg::MODE_IDLE;
      pend_r <= 3'd0;
      tlen_r <= '0;
    end else if (acc) begin
      mode_r <= mode_nxt;
      pend_r <= pend_nxt;
      tlen_r <= tlen_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (acc && id_we) begin
      ident_r[id_widx] <= in_byte;
    end
  end

endmodule

`default_nettype wire

### tb/tb.sv
// Testbench for c_subset_lexer_core: byte streams checked token by token against a predictor.
`timescale 1ns / 100ps

module tb;

  localparam int         KW_CHARS = 6;
  localparam logic [7:0] LEN_MAX  = 8'd255;

  localparam logic [8*8-1:0]  OP_CHARS    = "=+-|&!><";
  localparam logic [5*8-1:0]  OP_SECONDS  = "=+-|&";
  localparam logic [14*8-1:0] PUNCT_CHARS = "*/%(){},;:^~[]";

  typedef enum logic [5:0] {
    TOK_NULL, TOK_ID, TOK_VOID, TOK_INT, TOK_FLOAT, TOK_COMMA, TOK_COLON, TOK_LPAREN,
    TOK_RPAREN, TOK_ASSIGN, TOK_SEMI, TOK_LBRACE, TOK_RBRACE, TOK_PLUS, TOK_INC,
    TOK_STAR, TOK_CHAR, TOK_MINUS, TOK_END, TOK_DEC, TOK_SLASH, TOK_PERCENT, TOK_AMP,
    TOK_BAR, TOK_CARET, TOK_TILDE, TOK_ANDAND, TOK_OROR, TOK_BANG, TOK_EQ, TOK_NE,
    TOK_GT, TOK_LT, TOK_GE, TOK_LE, TOK_FOR, TOK_WHILE, TOK_DO, TOK_IF, TOK_ELSE,
    TOK_RETURN, TOK_LBRACK, TOK_RBRACK, TOK_INT_CONST, TOK_STRING, TOK_STRUCT, TOK_ERROR
  } tok_t;

  class lexer_scoreboard;
    csl_pkg::mode_t scan;
    logic [7:0]     op_first;
    logic [7:0]     word_head [KW_CHARS];
    logic [7:0]     run_len;
    csl_pkg::res_t  tokens_due [$];
    csl_pkg::res_t  step_tokens [$];
    int unsigned    mismatches;

    function new();
      scan       = csl_pkg::MODE_IDLE;
      op_first   = 8'h00;
      run_len    = 8'd0;
      mismatches = 0;
      foreach (word_head[i]) word_head[i] = 8'h00;
    endfunction

    function bit letter_char(input logic [7:0] b);
      return (b >= "a" && b <= "z") || (b >= "A" && b <= "Z") || b == csl_pkg::CH_UNDER;
    endfunction

    function bit digit_char(input logic [7:0] b);
      return b >= "0" && b <= "9";
    endfunction

    // Operator starter lookup: second char and the single / double kinds
    function bit op_info(input logic [7:0] b, output logic [7:0] second,
                         output tok_t one, output tok_t two);
      op_info = 1'b1;
      second  = "=";
      case (b)
        "=": begin one = TOK_ASSIGN; two = TOK_EQ; end
        "+": begin second = "+"; one = TOK_PLUS; two = TOK_INC; end
        "-": begin second = "-"; one = TOK_MINUS; two = TOK_DEC; end
        "|": begin second = "|"; one = TOK_BAR; two = TOK_OROR; end
        "&": begin second = "&"; one = TOK_AMP; two = TOK_ANDAND; end
        "!": begin one = TOK_BANG; two = TOK_NE; end
        ">": begin one = TOK_GT; two = TOK_GE; end
        "<": begin one = TOK_LT; two = TOK_LE; end
        default: begin op_info = 1'b0; one = TOK_ERROR; two = TOK_ERROR; end
      endcase
    endfunction

    function void add_token(input tok_t kind, input logic [7:0] len);
      csl_pkg::res_t r;
      r.kind = kind;
      r.len  = len;
      r.last = 1'b0;
      step_tokens.push_back(r);
    endfunction

    // Emit whatever token is still open and go idle
    function void flush_open();
      logic [47:0] word;
      logic [7:0]  second;
      tok_t        kind, one, two;
      word = {word_head[0], word_head[1], word_head[2],
              word_head[3], word_head[4], word_head[5]};
      kind = TOK_ID;
      case (scan)
        csl_pkg::MODE_IDENT: begin
          case (run_len)
            8'd2: begin
              if (word[47:32] == "do") kind = TOK_DO;
              else if (word[47:32] == "if") kind = TOK_IF;
            end
            8'd3: begin
              if (word[47:24] == "int") kind = TOK_INT;
              else if (word[47:24] == "for") kind = TOK_FOR;
            end
            8'd4: begin
              if (word[47:16] == "void") kind = TOK_VOID;
              else if (word[47:16] == "char") kind = TOK_CHAR;
              else if (word[47:16] == "else") kind = TOK_ELSE;
            end
            8'd5: begin
              if (word[47:8] == "float") kind = TOK_FLOAT;
              else if (word[47:8] == "while") kind = TOK_WHILE;
            end
            8'd6: begin
              if (word == "return") kind = TOK_RETURN;
              else if (word == "struct") kind = TOK_STRUCT;
            end
            default: ;
          endcase
          add_token(kind, run_len);
        end
        csl_pkg::MODE_NUMBER: add_token(TOK_INT_CONST, run_len);
        csl_pkg::MODE_STRING: add_token(TOK_ERROR, run_len);
        csl_pkg::MODE_OPER: begin
          void'(op_info(op_first, second, one, two));
          add_token(one, 8'd1);
        end
        default: ;
      endcase
      scan     = csl_pkg::MODE_IDLE;
      op_first = 8'h00;
      run_len  = 8'd0;
    endfunction

    function void note_byte(input logic [7:0] b, input logic eoi);
      logic [7:0] second, scratch;
      tok_t       one, two;
      step_tokens.delete();
      void'(op_info(op_first, second, one, two));
      if (eoi) begin
        flush_open();
        add_token(TOK_END, 8'd0);
      end else if (scan == csl_pkg::MODE_IDENT && (letter_char(b) || digit_char(b))) begin
        if (run_len < KW_CHARS) word_head[run_len[2:0]] = b;
        run_len += 8'(run_len != LEN_MAX);
      end else if (scan == csl_pkg::MODE_NUMBER && digit_char(b)) begin
        run_len += 8'(run_len != LEN_MAX);
      end else if (scan == csl_pkg::MODE_STRING) begin
        run_len += 8'(run_len != LEN_MAX);
        if (b == csl_pkg::CH_QUOTE) begin
          add_token(TOK_STRING, run_len);
          scan    = csl_pkg::MODE_IDLE;
          run_len = 8'd0;
        end
      end else if (scan == csl_pkg::MODE_OPER && b == second) begin
        add_token(two, 8'd2);
        scan     = csl_pkg::MODE_IDLE;
        op_first = 8'h00;
      end else begin
        flush_open();
        if (letter_char(b)) begin
          word_head[0] = b;
          run_len      = 8'd1;
          scan         = csl_pkg::MODE_IDENT;
        end else if (digit_char(b)) begin
          run_len = 8'd1;
          scan    = csl_pkg::MODE_NUMBER;
        end else if (b == csl_pkg::CH_QUOTE) begin
          run_len = 8'd1;
          scan    = csl_pkg::MODE_STRING;
        end else if (op_info(b, scratch, one, two)) begin
          op_first = b;
          scan     = csl_pkg::MODE_OPER;
        end else begin
          case (b)
            "*": add_token(TOK_STAR, 8'd1);
            "/": add_token(TOK_SLASH, 8'd1);
            "%": add_token(TOK_PERCENT, 8'd1);
            "(": add_token(TOK_LPAREN, 8'd1);
            ")": add_token(TOK_RPAREN, 8'd1);
            "{": add_token(TOK_LBRACE, 8'd1);
            "}": add_token(TOK_RBRACE, 8'd1);
            ",": add_token(TOK_COMMA, 8'd1);
            ";": add_token(TOK_SEMI, 8'd1);
            ":": add_token(TOK_COLON, 8'd1);
            "^": add_token(TOK_CARET, 8'd1);
            "~": add_token(TOK_TILDE, 8'd1);
            "[": add_token(TOK_LBRACK, 8'd1);
            "]": add_token(TOK_RBRACK, 8'd1);
            8'h20, 8'h09, 8'h0a, 8'h0d: ;
            8'h00: add_token(TOK_NULL, 8'd0);
            default: add_token(TOK_ERROR, 8'd1);
          endcase
        end
      end
      if (step_tokens.size() != 0) step_tokens[step_tokens.size() - 1].last = 1'b1;
      foreach (step_tokens[i]) tokens_due.push_back(step_tokens[i]);
    endfunction

    function void check_token(input logic [5:0] kind, input logic [7:0] len, input logic last);
      csl_pkg::res_t want;
      if (tokens_due.size() == 0) begin
        $error("unexpected token: token_kind %0d, lexeme_length %0d", kind, len);
        mismatches++;
        return;
      end
      want = tokens_due.pop_front();
      if (kind !== want.kind) begin
        $error("token_kind: expected %0d, got %0d", want.kind, kind);
        mismatches++;
      end
      if (len !== want.len) begin
        $error("lexeme_length: expected %0d, got %0d", want.len, len);
        mismatches++;
      end
      if (last !== want.last) begin
        $error("last: expected %0d, got %0d", want.last, last);
        mismatches++;
      end
    endfunction
  endclass

  logic       clk             = 1'b0;
  logic       rst_n           = 1'b0;
  logic       in_valid        = 1'b0;
  logic [7:0] in_byte         = 8'h00;
  logic       in_end_of_input = 1'b0;
  logic       out_ready       = 1'b0;
  logic       in_ready;
  logic       out_valid;
  logic [5:0] out_token_kind;
  logic [7:0] out_lexeme_length;
  logic       out_last;

  lexer_scoreboard book = new();
  int unsigned     in_idle_pct  = 15;
  int unsigned     out_idle_pct = 73;
  int unsigned     items_sent   = 0;

  c_subset_lexer_core i_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_byte           (in_byte),
    .in_end_of_input   (in_end_of_input),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_token_kind    (out_token_kind),
    .out_lexeme_length (out_lexeme_length),
    .out_last          (out_last)
  );

  always #2 clk = ~clk;

  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= out_idle_pct);
  end

  always @(posedge clk) begin
    if (rst_n && in_valid && in_ready) book.note_byte(in_byte, in_end_of_input);
    if (rst_n && out_valid && out_ready)
      book.check_token(out_token_kind, out_lexeme_length, out_last);
  end

  // Present one byte and hold it until the transfer; before it, idle at random as in_idle_pct sets
  task automatic send_byte(input logic [7:0] b, input logic eoi);
    while (in_idle_pct != 0 && $urandom_range(99) < in_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_byte         <= b;
    in_end_of_input <= eoi;
    do @(posedge clk); while (!in_ready);
    items_sent++;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i], 1'b0);
  endtask

  function automatic logic [7:0] rand_word_char(input bit lead);
    case ($urandom_range(lead ? 2 : 3))
      0: return 8'("a" + $urandom_range(25));
      1: return 8'("A" + $urandom_range(25));
      2: return csl_pkg::CH_UNDER;
      default: return 8'("0" + $urandom_range(9));
    endcase
  endfunction

  // One lexeme, mostly well formed; stretch draws a length from 254 to 258, around the 255 saturation point
  task automatic send_token(input int unsigned pick, input bit stretch);
    string       w;
    logic [7:0]  b;
    int unsigned span, variant;
    span = $urandom_range(254, 258);
    if (pick < 15) begin
      case ($urandom_range(10))
        0: w = "void";
        1: w = "int";
        2: w = "float";
        3: w = "char";
        4: w = "for";
        5: w = "while";
        6: w = "do";
        7: w = "if";
        8: w = "else";
        9: w = "return";
        default: w = "struct";
      endcase
      variant = $urandom_range(7);
      if (variant == 6) w = {w, "s"};
      else if (variant == 7) w = w.substr(0, w.len() - 2);
      send_text(w);
    end else if (pick < 30) begin
      if (!stretch) span = $urandom_range(1, 8);
      send_byte(rand_word_char(1'b1), 1'b0);
      repeat (span - 1) send_byte(rand_word_char(1'b0), 1'b0);
    end else if (pick < 42) begin
      if (!stretch) span = $urandom_range(1, 5);
      repeat (span) send_byte(8'("0" + $urandom_range(9)), 1'b0);
    end else if (pick < 52) begin
      if (!stretch) span = $urandom_range(2, 8);
      send_byte(csl_pkg::CH_QUOTE, 1'b0);
      repeat (span - 2) begin
        do b = 8'($urandom_range(255)); while (b == csl_pkg::CH_QUOTE);
        send_byte(b, 1'b0);
      end
      send_byte(csl_pkg::CH_QUOTE, 1'b0);
    end else if (pick < 64) begin
      send_byte(OP_CHARS[8*$urandom_range(7) +: 8], 1'b0);
      if ($urandom_range(1)) send_byte(OP_SECONDS[8*$urandom_range(4) +: 8], 1'b0);
    end else if (pick < 74) begin
      send_byte(PUNCT_CHARS[8*$urandom_range(13) +: 8], 1'b0);
    end else if (pick < 86) begin
      case ($urandom_range(3))
        0: send_byte(8'h20, 1'b0);
        1: send_byte(8'h09, 1'b0);
        2: send_byte(8'h0a, 1'b0);
        default: send_byte(8'h0d, 1'b0);
      endcase
    end else if (pick < 90) begin
      send_byte(8'h00, 1'b0);
    end else if (pick < 96) begin
      send_byte(8'($urandom_range(255)), 1'b0);
    end else begin
      send_byte(8'($urandom_range(255)), 1'b1);
    end
  endtask

  initial begin
    int unsigned phase_end;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // null, top byte, string holding a null, keyword, double op, number, unknown byte
    send_byte(8'h00, 1'b0);
    send_byte(8'hff, 1'b0);
    send_byte(csl_pkg::CH_QUOTE, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(csl_pkg::CH_QUOTE, 1'b0);
    send_text("while!=9@");
    send_byte(8'h00, 1'b1);
    // string still open at end, then pending operator at end
    send_text("\"x");
    send_byte(8'hff, 1'b1);
    send_text("return<");
    send_byte(8'h00, 1'b1);

    for (int ph = 0; ph < 3; ph++) begin
      in_idle_pct  = (ph == 0) ? 15 : (ph == 1) ? 73 : 0;
      out_idle_pct = (ph == 0) ? 73 : (ph == 1) ? 15 : 0;
      phase_end    = items_sent + 450;
      send_token((ph == 0) ? 20 : (ph == 1) ? 35 : 45, 1'b1);
      while (items_sent < phase_end) send_token($urandom_range(99), 1'b0);
    end
    send_byte(8'h00, 1'b1);
    in_valid <= 1'b0;

    while (book.tokens_due.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (book.mismatches == 0 && book.tokens_due.size() == 0) begin
      $display("c_subset_lexer_core test passed");
    end else begin
      $display("c_subset_lexer_core test failed");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("c_subset_lexer_core test failed");
    $finish;
  end

endmodule
